@@ rtl/csem_pkg.sv @@
`timescale 1ns / 1ps
// package for the counting semaphore with fifo wait queue
// holds queue sizing, request/result structs and codes; no dependencies

package csem_pkg;

  // queue sizing
  localparam int QUEUE_DEPTH  = 32;
  localparam int TASK_ID_BITS = 8;

  // stored id width, never wider than the task_id field
  localparam int ID_W   = (TASK_ID_BITS < 8) ? TASK_ID_BITS : 8;
  localparam int HEAD_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W  = FILL_W + 1;

  // count limits
  localparam logic signed [15:0] COUNT_MAX = 16'sh7fff;
  localparam logic signed [15:0] COUNT_MIN = 16'sh8000;

  // action codes
  localparam logic ACT_DOWN = 1'b0;
  localparam logic ACT_UP   = 1'b1;

  // error codes
  localparam logic [1:0] ERR_NONE    = 2'd0;
  localparam logic [1:0] ERR_REFUSED = 2'd1;
  localparam logic [1:0] ERR_SAT     = 2'd2;

  // one request
  typedef struct packed {
    logic       action;
    logic [7:0] task_id;
  } in_req_t;

  // one result
  typedef struct packed {
    logic               blocked;
    logic               woken_valid;
    logic [7:0]         woken_task;
    logic signed [15:0] count_now;
    logic [1:0]         error;
  } out_res_t;

endpackage

@@ rtl/counting_semaphore_fifo_wait_queue.sv @@
`timescale 1ns / 1ps
// counting semaphore with a fifo wait queue held in a ring memory
// depends on csem_pkg

// Takes one down/up request per cycle while out_ready is high. A request is
// accepted, its count and queue pointers are updated at once, and its result
// is loaded into the read stage register at the accepting edge and from there
// into the output register, which raises out_valid. The accepting edge also
// performs the synchronous read of the wait queue memory at the head (used when
// an up wakes a waiter). While the output is held, one more request can wait
// behind it, and then in_ready drops. The count, head and fill live in flip-flops;
// only the queue of waiting task ids lives in the memory, written at the tail
// by a blocking down and read at the head by a waking up. A write of
// initial_count reloads the count and empties the queue; it must come while
// no request is in flight. There is no clearing pass after reset.
module counting_semaphore_fifo_wait_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [14:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  csem_pkg::in_req_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output csem_pkg::out_res_t out_data
);
  import csem_pkg::*;

  logic [ID_W-1:0]    mem [QUEUE_DEPTH];
  logic [ID_W-1:0]    rd_data_r;

  logic signed [15:0] count_r, count_nxt;
  logic [HEAD_W-1:0]  head_r, head_nxt;
  logic [FILL_W-1:0]  fill_r, fill_nxt;

  logic               s1_valid_r;
  out_res_t           s1_res_r, s1_res_nxt;
  logic               out_valid_r;
  out_res_t           out_res_r, out_res_nxt;

  logic               s1_adv;
  logic               in_acc;
  logic               wr_en;
  logic               rd_en;
  logic [SUM_W-1:0]   tail_sum;
  logic [HEAD_W-1:0]  tail_idx;
  logic [HEAD_W-1:0]  head_inc;
  logic signed [15:0] count_dec;
  logic signed [15:0] count_inc;

  // handshake
  assign s1_adv   = !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || s1_adv;
  assign in_acc   = in_valid && in_ready;

  // ring positions
  assign tail_sum = SUM_W'(head_r) + SUM_W'(fill_r);
  assign tail_idx = (tail_sum >= SUM_W'(QUEUE_DEPTH)) ?
                    HEAD_W'(tail_sum - SUM_W'(QUEUE_DEPTH)) : HEAD_W'(tail_sum);
  assign head_inc = (32'(head_r) == QUEUE_DEPTH - 1) ? '0 : head_r + HEAD_W'(1);

  assign count_dec = count_r - 16'sd1;
  assign count_inc = count_r + 16'sd1;

  // request decision
  always_comb begin
    count_nxt  = count_r;
    head_nxt   = head_r;
    fill_nxt   = fill_r;
    wr_en      = 1'b0;
    rd_en      = 1'b0;
    s1_res_nxt = '0;
    if (in_data.action == ACT_DOWN) begin
      if (count_r <= 16'sd0 &&
          (32'(fill_r) >= QUEUE_DEPTH || count_r == COUNT_MIN)) begin
        s1_res_nxt.error = ERR_REFUSED;
      end else begin
        count_nxt = count_dec;
        if (count_dec < 16'sd0) begin
          wr_en              = in_acc;
          fill_nxt           = fill_r + FILL_W'(1);
          s1_res_nxt.blocked = 1'b1;
        end
      end
    end else begin
      if (count_r == COUNT_MAX) begin
        s1_res_nxt.error = ERR_SAT;
      end else begin
        count_nxt = count_inc;
        if (count_inc <= 16'sd0 && fill_r != '0) begin
          rd_en                  = in_acc;
          head_nxt               = head_inc;
          fill_nxt               = fill_r - FILL_W'(1);
          s1_res_nxt.woken_valid = 1'b1;
        end
      end
    end
    s1_res_nxt.count_now = count_nxt;
  end

  // wait queue memory
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[tail_idx] <= in_data.task_id[ID_W-1:0];
    end
    if (rd_en) begin
      rd_data_r <= mem[head_r];
    end
  end

  // semaphore state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= 16'sd1;
      head_r  <= '0;
      fill_r  <= '0;
    end else if (cfg_we) begin
      count_r <= signed'({1'b0, cfg_wdata});
      head_r  <= '0;
      fill_r  <= '0;
    end else if (in_acc) begin
      count_r <= count_nxt;
      head_r  <= head_nxt;
      fill_r  <= fill_nxt;
    end
  end

  // read stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_res_r <= s1_res_nxt;
    end
  end

  // result with the woken id filled in
  always_comb begin
    out_res_nxt            = s1_res_r;
    out_res_nxt.woken_task = s1_res_r.woken_valid ? 8'(rd_data_r) : 8'd0;
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_valid_r) begin
      out_res_r <= out_res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_res_r;

endmodule
